// File: design/wlh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wlh_pkg;

    localparam int BINS   = 32;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int BIN_AW = $clog2(BINS);

    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7A;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] word_total;
        logic [6:0]  shortest_len;
        logic [6:0]  longest_len;
        logic        longest_over;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic              text_acc;
        logic              end_acc;
        logic              emit_load;
        logic              emit_last;
        logic [BIN_AW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: design/wlh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wlh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_func,
    input  wire wlh_pkg::t_status i_status,
    output logic                o_in_ready,
    output wlh_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [wlh_pkg::BIN_AW-1:0]  r_idx, n_idx;
    logic                        acc;
    logic                        load;
    logic                        last_bin;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign load       = (r_state == S_EMIT) && i_status.out_free;
    assign last_bin   = (r_idx == wlh_pkg::BIN_AW'(wlh_pkg::BINS - 1));

    always_comb begin
        o_cmd.text_acc  = acc && !i_func;
        o_cmd.end_acc   = acc && i_func;
        o_cmd.emit_load = load;
        o_cmd.emit_last = load && last_bin;
        o_cmd.idx       = r_idx;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (acc && i_func) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (last_bin) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule
`default_nettype wire

// File: design/wlh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module wlh_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wlh_pkg::t_cmd     i_cmd,
    input  wire logic [7:0]        i_ch,
    output wlh_pkg::t_status       o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output wlh_pkg::t_out_item     o_out_data
);

    localparam logic [wlh_pkg::LEN_W-1:0] LEN_MAX = wlh_pkg::LEN_W'(wlh_pkg::BINS);

    logic [wlh_pkg::CNT_W-1:0]  r_bins [wlh_pkg::BINS];
    logic                       r_inside;
    logic [wlh_pkg::LEN_W-1:0]  r_cur_len;
    logic [wlh_pkg::CNT_W-1:0]  r_words;
    logic [wlh_pkg::LEN_W-1:0]  r_min;
    logic [wlh_pkg::LEN_W-1:0]  r_max;
    logic                       r_out_valid;
    wlh_pkg::t_out_item         r_out;

    logic                       letter;
    logic                       record;
    logic [wlh_pkg::LEN_W-1:0]  len_m1;
    logic [wlh_pkg::BIN_AW-1:0] rd_addr;
    logic [wlh_pkg::CNT_W-1:0]  rd_data;
    logic [wlh_pkg::CNT_W-1:0]  bin_inc;
    logic [wlh_pkg::CNT_W-1:0]  words_inc;

    assign letter = ((i_ch >= wlh_pkg::CH_LC_A) && (i_ch <= wlh_pkg::CH_LC_Z))
                 || ((i_ch >= wlh_pkg::CH_UC_A) && (i_ch <= wlh_pkg::CH_UC_Z));
    assign record = r_inside && ((i_cmd.text_acc && !letter) || i_cmd.end_acc);

    assign len_m1    = r_cur_len - 1'b1;
    assign rd_addr   = i_cmd.emit_load ? i_cmd.idx : len_m1[wlh_pkg::BIN_AW-1:0];
    assign rd_data   = r_bins[rd_addr];
    assign bin_inc   = (&rd_data) ? rd_data : rd_data + 1'b1;
    assign words_inc = (&r_words) ? r_words : r_words + 1'b1;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wlh_pkg::BINS; k++) begin
                r_bins[k] <= '0;
            end
        end else if (i_cmd.emit_load) begin
            r_bins[rd_addr] <= '0;
        end else if (record) begin
            r_bins[rd_addr] <= bin_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_cur_len <= '0;
        end else if (i_cmd.text_acc && letter) begin
            r_inside <= 1'b1;
            if (!r_inside) begin
                r_cur_len <= wlh_pkg::LEN_W'(1);
            end else if (r_cur_len < LEN_MAX) begin
                r_cur_len <= r_cur_len + 1'b1;
            end
        end else if (i_cmd.text_acc || i_cmd.end_acc) begin
            r_inside  <= 1'b0;
            r_cur_len <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.emit_last) begin
            r_words <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (record) begin
            r_words <= words_inc;
            if ((r_min == '0) || (r_cur_len < r_min)) begin
                r_min <= r_cur_len;
            end
            if (r_cur_len > r_max) begin
                r_max <= r_cur_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out.bin_index    <= wlh_pkg::IDX_W'(i_cmd.idx);
            r_out.bin_count    <= 32'(rd_data);
            r_out.word_total   <= 32'(r_words);
            r_out.shortest_len <= r_min;
            r_out.longest_len  <= r_max;
            r_out.longest_over <= (r_max >= LEN_MAX);
            r_out.last         <= i_cmd.emit_last;
        end
    end

endmodule
`default_nettype wire

// File: design/word_length_histogram_unit.sv
// Text beat: accepted every cycle while no bin run is in progress, produces no result.
// End beat: moves the controller to its emit state; each bin is then registered out,
// one bin per cycle while the sink is ready; BINS beats in all, sequenced by the bin counter.
// Input is held off during the bin run.
// Synchronous active-low reset clears all counts, bins and handshake state at once.
`timescale 1ns / 1ps
`default_nettype none
module word_length_histogram_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire wlh_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output wlh_pkg::t_out_item      o_out_data
);

    wlh_pkg::t_cmd    cmd;
    wlh_pkg::t_status status;

    wlh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    wlh_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_ch        (i_in_data.ch),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import wlh_pkg::*;

    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_END  = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_CYCLES = 400;
    localparam int   MAX_REPORTS = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycles = 0;

    word_length_histogram_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    class hist_scoreboard;
        bit          in_word;
        logic [6:0]  run_len;
        logic [31:0] bin_tally [BINS];
        logic [31:0] word_tally;
        logic [6:0]  min_len;
        logic [6:0]  max_len;
        t_out_item   expected_bins [$];
        int          errors;
        int          reported;

        function new();
            errors = 0;
            reported = 0;
            clear_hist();
        endfunction

        function void clear_hist();
            in_word = 1'b0;
            run_len = '0;
            foreach (bin_tally[k]) bin_tally[k] = '0;
            word_tally = '0;
            min_len = '0;
            max_len = '0;
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        function void record_word();
            logic [6:0] len;
            len = (run_len > BINS) ? 7'(BINS) : run_len;
            if (len == 0) return;
            bin_tally[len - 1] = sat_inc(bin_tally[len - 1]);
            word_tally = sat_inc(word_tally);
            if (min_len == 0 || len < min_len) min_len = len;
            if (len > max_len) max_len = len;
        endfunction

        function void note_beat(t_in_item b);
            t_out_item e;
            if (b.func == FUNC_TEXT) begin
                if (is_letter(b.ch)) begin
                    if (in_word) begin
                        if (run_len < BINS) run_len++;
                    end else begin
                        in_word = 1'b1;
                        run_len = 7'd1;
                    end
                end else begin
                    if (in_word) record_word();
                    in_word = 1'b0;
                    run_len = '0;
                end
            end else begin
                if (in_word) record_word();
                for (int k = 0; k < BINS; k++) begin
                    e.bin_index    = 6'(k);
                    e.bin_count    = bin_tally[k];
                    e.word_total   = word_tally;
                    e.shortest_len = min_len;
                    e.longest_len  = max_len;
                    e.longest_over = (max_len >= BINS);
                    e.last         = (k == BINS - 1);
                    expected_bins.push_back(e);
                end
                clear_hist();
            end
        endfunction

        function void check_bin(t_out_item got);
            t_out_item want;
            if (expected_bins.size() == 0) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected bin beat: idx=%0d cnt=%0d", got.bin_index,
                             got.bin_count);
                end
                return;
            end
            want = expected_bins.pop_front();
            if (got.bin_index !== want.bin_index || got.bin_count !== want.bin_count ||
                got.word_total !== want.word_total ||
                got.shortest_len !== want.shortest_len ||
                got.longest_len !== want.longest_len ||
                got.longest_over !== want.longest_over || got.last !== want.last) begin
                errors++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display({"bin mismatch: exp idx=%0d cnt=%0d tot=%0d min=%0d",
                              " max=%0d over=%0b last=%0b"},
                             want.bin_index, want.bin_count, want.word_total,
                             want.shortest_len, want.longest_len, want.longest_over,
                             want.last);
                    $display({"              got idx=%0d cnt=%0d tot=%0d min=%0d",
                              " max=%0d over=%0b last=%0b"},
                             got.bin_index, got.bin_count, got.word_total,
                             got.shortest_len, got.longest_len, got.longest_over,
                             got.last);
                end
            end
        endfunction
    endclass

    hist_scoreboard sb = new();

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sink side: check each accepted bin beat, then choose ready for the next cycle
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_bin(out_data);
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (hold_req != 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic f, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{func: f, ch: c};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_beat('{func: f, ch: c});
    endtask

    task automatic run_phase(input int target);
        int sent;
        int pick;
        int len;
        logic [7:0] c;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_beat(FUNC_END, 8'($urandom_range(255)));
                sent++;
            end else if (pick < 18) begin
                send_beat(FUNC_TEXT, 8'($urandom_range(255)));
                sent++;
            end else begin
                len = ($urandom_range(99) < 5) ? $urandom_range(BINS - 2, BINS + 8)
                                               : $urandom_range(1, 9);
                repeat (len) begin
                    c = 8'($urandom_range(25)) + ($urandom_range(1) ? CH_LC_A : CH_UC_A);
                    send_beat(FUNC_TEXT, c);
                end
                do c = 8'($urandom_range(255)); while (is_letter(c));
                send_beat(FUNC_TEXT, c);
                sent += len + 1;
            end
        end
        send_beat(FUNC_END, 8'($urandom_range(255)));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(FUNC_END, 8'h00);
        send_beat(FUNC_TEXT, CH_LC_A);
        send_beat(FUNC_TEXT, CH_LC_Z);
        send_beat(FUNC_TEXT, CH_UC_A);
        send_beat(FUNC_TEXT, CH_UC_Z);
        send_beat(FUNC_TEXT, CH_UC_A - 8'd1);
        send_beat(FUNC_TEXT, CH_LC_Z);
        send_beat(FUNC_TEXT, CH_UC_Z + 8'd1);
        send_beat(FUNC_TEXT, CH_LC_A - 8'd1);
        send_beat(FUNC_TEXT, CH_LC_Z + 8'd1);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, CH_UC_A);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, CH_LC_A + 8'd1);
        send_beat(FUNC_TEXT, CH_UC_Z - 8'd1);
        send_beat(FUNC_END, 8'hFF);
        send_beat(FUNC_END, 8'h5A);

        send_idle_pct = 19;
        recv_idle_pct = 75;
        run_phase(40);

        send_idle_pct = 75;
        recv_idle_pct = 19;
        run_phase(40);

        // long sink stall with the source still pushing
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_beat(FUNC_TEXT, CH_LC_A);
        hold_req = 1;
        send_beat(FUNC_END, 8'h00);
        run_phase(40);

        in_valid <= 1'b0;
        while (sb.expected_bins.size() != 0) @(posedge clk);
        repeat (BINS + 8) @(posedge clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
